### src/dsr_pkg.sv
`timescale 1ns / 1ps

package dsr_pkg;

    // Widths fixed by the transaction fields and the register map.
    localparam int ELEM_W     = 32;
    localparam int DIM_W      = 4;
    localparam int MODE_W     = 2;
    localparam int TOT_W      = 2 * DIM_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam int OCC_W      = 2;
    localparam int WIDE_W     = 64;

    // Defaults for the top-level parameters.
    localparam int MAX_DIM_DEF    = 8;
    localparam int DATA_WIDTH_DEF = 32;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_DIM = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 1'd1;

    // Scan modes. The unused code behaves as the zigzag.
    localparam logic [MODE_W-1:0] MODE_UP     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DOWN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ZIGZAG = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    // Read request from the scan sequencer to the store.
    typedef struct packed {
        logic issue;
        logic last;
    } dsr_rd_t;

    // Lowest row on anti-diagonal s of an n by n matrix.
    function automatic logic [DIM_W-1:0] diag_lo(input logic [DIM_W-1:0] s,
                                                 input logic [DIM_W-1:0] n);
        logic [DIM_W-1:0] lo;
        lo = '0;
        if (s >= n)
        begin
            lo = s - n + 1'b1;
        end
        return lo;
    endfunction

    // Highest row on anti-diagonal s of an n by n matrix.
    function automatic logic [DIM_W-1:0] diag_hi(input logic [DIM_W-1:0] s,
                                                 input logic [DIM_W-1:0] n);
        logic [DIM_W-1:0] hi;
        hi = n - 1'b1;
        if (s < n)
        begin
            hi = s;
        end
        return hi;
    endfunction

endpackage

### src/dsr_if.sv
`timescale 1ns / 1ps

interface dsr_elem_if;
    import dsr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] elem_value;

    modport source (output valid, output elem_value, input ready);
    modport sink (input valid, input elem_value, output ready);
endinterface

interface dsr_scan_if;
    import dsr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] out_value;
    logic                     out_last;

    modport source (output valid, output out_value, output out_last, input ready);
    modport sink (input valid, input out_value, input out_last, output ready);
endinterface

### src/dsr_store.sv
`timescale 1ns / 1ps

module dsr_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### src/dsr_scan_gen.sv
`timescale 1ns / 1ps

module dsr_scan_gen #(
    parameter int AW = 6
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [dsr_pkg::DIM_W-1:0]  dim,
    input  logic [dsr_pkg::MODE_W-1:0] mode,
    input  logic                     space,
    output logic                     busy,
    output dsr_pkg::dsr_rd_t         rd,
    output logic [AW-1:0]            addr
);
    import dsr_pkg::*;

    logic [DIM_W-1:0] s_reg, s_next;
    logic [DIM_W-1:0] r_reg, r_next;
    logic             busy_reg, busy_next;

    logic [DIM_W-1:0] s_inc;
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] last_s;
    logic [DIM_W:0]   twice_dim;
    logic [TOT_W-1:0] lin;
    logic             up_cur;
    logic             up_inc;
    logic             at_end;
    logic             is_last;
    logic             issue;

    // Walking direction of a diagonal: zigzag goes upward on even diagonals.
    function automatic logic walk_up(input logic [DIM_W-1:0] s,
                                     input logic [MODE_W-1:0] m);
        logic up;
        up = ~s[0];
        if (m == MODE_UP)
        begin
            up = 1'b1;
        end
        else if (m == MODE_DOWN)
        begin
            up = 1'b0;
        end
        return up;
    endfunction

    always_comb
    begin
        s_inc     = s_reg + 1'b1;
        col       = s_reg - r_reg;
        lin       = TOT_W'(r_reg) * TOT_W'(dim) + TOT_W'(col);
        twice_dim = {dim, 1'b0} - (DIM_W+1)'(2);
        last_s    = twice_dim[DIM_W-1:0];
        up_cur    = walk_up(s_reg, mode);
        up_inc    = walk_up(s_inc, mode);
        at_end    = up_cur ? (r_reg == diag_lo(s_reg, dim)) : (r_reg == diag_hi(s_reg, dim));
        is_last   = (s_reg == last_s);
        issue     = busy_reg & space;

        s_next    = s_reg;
        r_next    = r_reg;
        busy_next = busy_reg;
        if (start)
        begin
            s_next    = '0;
            r_next    = '0;
            busy_next = 1'b1;
        end
        else if (issue)
        begin
            if (is_last)
            begin
                busy_next = 1'b0;
            end
            else if (at_end)
            begin
                s_next = s_inc;
                r_next = up_inc ? diag_hi(s_inc, dim) : diag_lo(s_inc, dim);
            end
            else
            begin
                r_next = up_cur ? (r_reg - 1'b1) : (r_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg    <= '0;
            r_reg    <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            s_reg    <= s_next;
            r_reg    <= r_next;
            busy_reg <= busy_next;
        end
    end

    assign busy     = busy_reg;
    assign rd.issue = issue;
    assign rd.last  = is_last;
    assign addr     = lin[AW-1:0];
endmodule

### src/dsr_out_buf.sv
`timescale 1ns / 1ps

module dsr_out_buf (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic signed [dsr_pkg::ELEM_W-1:0] push_value,
    input  logic                             push_last,
    input  logic                             pop,
    output logic                             valid,
    output logic signed [dsr_pkg::ELEM_W-1:0] head_value,
    output logic                             head_last,
    output logic [dsr_pkg::OCC_W-1:0]         occ
);
    import dsr_pkg::*;

    logic signed [ELEM_W-1:0] value_reg [2];
    logic                     last_reg [2];
    logic                     wptr_reg, wptr_next;
    logic                     rptr_reg, rptr_next;
    logic [OCC_W-1:0]         occ_reg, occ_next;

    always_comb
    begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ pop;
        occ_next  = occ_reg + OCC_W'(push) - OCC_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            occ_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            occ_reg  <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            value_reg[wptr_reg] <= push_value;
            last_reg[wptr_reg]  <= push_last;
        end
    end

    assign valid      = (occ_reg != '0);
    assign head_value = value_reg[rptr_reg];
    assign head_last  = last_reg[rptr_reg];
    assign occ        = occ_reg;
endmodule

### src/diagonal_scan_reorder.sv
`timescale 1ns / 1ps
// Start of scan: once the last element is taken the sequencer goes busy; the first read is
// registered in the store and then in the output buffer, which offers it to the scan port.
// Throughput: load, then one scan read per cycle (one read port) while the buffer has room.
// Reset: asynchronous, active low; matrix_dim returns to 8, mode to zigzag, load count to 0.
// The matrix store is not cleared; every entry is written before it is read.

module diagonal_scan_reorder #(
    parameter int MAX_DIM    = dsr_pkg::MAX_DIM_DEF,
    parameter int DATA_WIDTH = dsr_pkg::DATA_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    dsr_elem_if.sink                          elem,
    dsr_scan_if.source                        scan,
    input  logic                              cfg_we,
    input  logic [dsr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dsr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import dsr_pkg::*;

    // The store holds one matrix of at most MAX_DIM by MAX_DIM words.
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    // Configuration registers.
    logic [DIM_W-1:0]  dim_reg;
    logic [MODE_W-1:0] mode_reg;

    // Load counter: number of elements written into the store so far.
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     count_inc;

    // A read issued in one cycle returns its data in the next; these flag it.
    logic              pend_reg;
    logic              pend_last_reg;

    logic [DIM_W-1:0]  dim_act;
    logic [TOT_W-1:0]  total;
    logic              in_acc;
    logic              start;
    logic              busy;
    logic              space;
    logic              pop;
    logic [OCC_W-1:0]  occ;
    logic [OCC_W-1:0]  fill;
    dsr_rd_t           rd;
    logic [AW-1:0]     raddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [DATA_WIDTH-1:0] rdata;
    logic [WIDE_W-1:0] rdata_wide;

    // A zero dimension behaves as one; a dimension above MAX_DIM is clipped to it.
    always_comb
    begin
        dim_act = dim_reg;
        if (dim_reg == '0)
        begin
            dim_act = DIM_W'(1);
        end
        else if (dim_reg > DIM_W'(MAX_DIM))
        begin
            dim_act = DIM_W'(MAX_DIM);
        end
        total = TOT_W'(dim_act) * TOT_W'(dim_act);
    end

    // Configuration writes must arrive only while the block is idle; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg  <= DIM_RESET;
            mode_reg <= MODE_ZIGZAG;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MATRIX_DIM: dim_reg  <= cfg_data[DIM_W-1:0];
                REG_MODE:       mode_reg <= cfg_data[MODE_W-1:0];
                default:        ;
            endcase
        end
    end

    // Loading. The input is held off while a scan is being issued so that
    // no element overwrites an entry still waiting to be read. Once the
    // count reaches n*n (also after the dimension was lowered mid-load)
    // the counter clears and the scan sequencer starts.
    assign elem.ready = ~busy;
    assign in_acc     = elem.valid & elem.ready;

    always_comb
    begin
        count_inc  = count_reg + 1'b1;
        count_next = count_reg;
        start      = 1'b0;
        if (in_acc)
        begin
            if (TOT_W'(count_inc) >= total)
            begin
                count_next = '0;
                start      = 1'b1;
            end
            else
            begin
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pend_reg      <= rd.issue;
            pend_last_reg <= rd.issue & rd.last;
        end
    end

    // Stored words keep the low DATA_WIDTH bits of the element.
    assign wdata = DATA_WIDTH'({{(WIDE_W-ELEM_W){1'b0}}, elem.elem_value});

    dsr_store #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (DATA_WIDTH)
    ) u_store (
        .clk   (clk),
        .we    (in_acc),
        .waddr (count_reg[AW-1:0]),
        .wdata (wdata),
        .re    (rd.issue),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Credit check: the output buffer has two entries, and a read in flight
    // already owns one. A read may be issued when the entries held plus the
    // one in flight, less any leaving this cycle, stay below two.
    assign pop   = scan.valid & scan.ready;
    assign fill  = occ + OCC_W'(pend_reg);
    assign space = (fill != OCC_W'(2)) | pop;

    dsr_scan_gen #(
        .AW    (AW)
    ) u_scan_gen (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .dim   (dim_act),
        .mode  (mode_reg),
        .space (space),
        .busy  (busy),
        .rd    (rd),
        .addr  (raddr)
    );

    // The word leaves as its low 32 bits, zero-filled when the store is narrower.
    assign rdata_wide = WIDE_W'(rdata);

    dsr_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (pend_reg),
        .push_value (rdata_wide[ELEM_W-1:0]),
        .push_last  (pend_last_reg),
        .pop        (pop),
        .valid      (scan.valid),
        .head_value (scan.out_value),
        .head_last  (scan.out_last),
        .occ        (occ)
    );
endmodule
